>>> rtl/core/ilid_pkg.sv
package ilid_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 8;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int DATA_W   = 32;

  // two-level read select, both levels at least one bit wide
  localparam int SEL_W = (IDX_W < 2) ? 2 : IDX_W;
  localparam int LO_W  = SEL_W / 2;
  localparam int HI_W  = SEL_W - LO_W;
  localparam int GRP   = 2 ** LO_W;
  localparam int NGRP  = 2 ** HI_W;
  localparam int NPAD  = GRP * NGRP;

  localparam logic signed [DATA_W-1:0] VALUE_NONE = -32'sd1;

  typedef enum logic [2:0] {
    REQ_INSERT_AT    = 3'd0,
    REQ_DELETE_AT    = 3'd1,
    REQ_READ_AT      = 3'd2,
    REQ_APPEND       = 3'd3,
    REQ_PREPEND      = 3'd4,
    REQ_DELETE_LAST  = 3'd5,
    REQ_DELETE_FIRST = 3'd6,
    REQ_READ_LAST    = 3'd7
  } ilid_req_e;

  typedef struct packed {
    logic                     shift_up;
    logic                     shift_down;
    logic [IDX_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
  } ilid_cell_ctrl_t;

endpackage

>>> rtl/core/ilid_if.sv
interface ilid_req_if;
  import ilid_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [2:0]               req_type;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value_in;

  modport source (output valid, req_type, position, value_in, input ready);
  modport sink   (input valid, req_type, position, value_in, output ready);
endinterface

interface ilid_rsp_if;
  import ilid_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     accepted;
  logic signed [DATA_W-1:0] value_out;
  logic [7:0]               count_out;

  modport source (output valid, accepted, value_out, count_out, input ready);
  modport sink   (input valid, accepted, value_out, count_out, output ready);
endinterface

>>> rtl/core/ilid_cell.sv
module ilid_cell import ilid_pkg::*; (
  input  logic                     clk_i,
  input  logic [IDX_W-1:0]         idx_i,
  input  ilid_cell_ctrl_t          ctrl_i,
  input  logic signed [DATA_W-1:0] prev_i,
  input  logic signed [DATA_W-1:0] next_i,
  output logic signed [DATA_W-1:0] value_o
);

  logic signed [DATA_W-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.shift_up) begin
      if (idx_i == ctrl_i.pos) begin
        val_d = ctrl_i.value;
      end else if (idx_i > ctrl_i.pos) begin
        val_d = prev_i;
      end
    end else if (ctrl_i.shift_down && (idx_i >= ctrl_i.pos)) begin
      val_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign value_o = val_q;

endmodule

>>> rtl/core/ilid_rdgrp.sv
module ilid_rdgrp import ilid_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [DATA_W-1:0] ent_i [GRP],
  input  logic [LO_W-1:0]          sel_i,
  output logic signed [DATA_W-1:0] data_o
);

  logic signed [DATA_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= ent_i[sel_i];
    end
  end

  assign data_o = data_q;

endmodule

>>> rtl/core/indexed_list_insert_delete.sv
// channel | dir | transfer when       | payload
// req_i   | in  | valid && ready      | req_type, position, value_in
// rsp_o   | out | valid && ready      | accepted, value_out, count_out
//
// each request is handled in the accept cycle, which shifts the cell row and picks
// one entry per read group, and then in the run state, which picks the group and
// loads the result register; the two-level read select sets this split
// a new request is taken while the previous result still waits in the result register
// a stalled result holds the block in its run state until it is taken
// reset clears the entry count, the state and the result valid; cell contents are not reset
module indexed_list_insert_delete import ilid_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ilid_req_if.sink   req_i,
  ilid_rsp_if.source rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } ilid_state_e;

  ilid_state_e state_q, state_d;

  logic [CNT_W-1:0] count_q, count_d;
  logic             ok_q, is_read_q;
  logic [HI_W-1:0]  rd_hi_q;

  logic                     rsp_valid_q;
  logic                     rsp_acc_q;
  logic signed [DATA_W-1:0] rsp_val_q;
  logic [7:0]               rsp_cnt_q;

  // request decode
  logic             req_xfer;
  logic             ok, is_read, is_ins, is_del;
  logic [CMP_W-1:0] pos_w, cnt_w;
  logic             full, empty;
  logic [IDX_W-1:0] mod_pos;
  logic [SEL_W-1:0] rd_idx;
  logic [CNT_W-1:0] last_idx;
  ilid_cell_ctrl_t  ctrl;

  assign req_i.ready = state_q[0];
  assign req_xfer    = req_i.valid && req_i.ready;

  assign pos_w    = CMP_W'(req_i.position);
  assign cnt_w    = CMP_W'(count_q);
  assign full     = (count_q == CNT_W'(CAPACITY));
  assign empty    = (count_q == '0);
  assign last_idx = count_q - CNT_W'(1);

  always_comb begin
    ok      = 1'b0;
    is_read = 1'b0;
    is_ins  = 1'b0;
    is_del  = 1'b0;
    mod_pos = '0;
    rd_idx  = '0;
    case (ilid_req_e'(req_i.req_type))
      REQ_INSERT_AT: begin
        is_ins  = 1'b1;
        ok      = (pos_w <= cnt_w) && !full;
        mod_pos = IDX_W'(req_i.position);
      end
      REQ_APPEND: begin
        is_ins  = 1'b1;
        ok      = !full;
        mod_pos = IDX_W'(count_q);
      end
      REQ_PREPEND: begin
        is_ins  = 1'b1;
        ok      = !full;
      end
      REQ_DELETE_AT: begin
        is_del  = 1'b1;
        ok      = pos_w < cnt_w;
        mod_pos = IDX_W'(req_i.position);
      end
      REQ_DELETE_LAST: begin
        is_del  = 1'b1;
        ok      = !empty;
        mod_pos = IDX_W'(last_idx);
      end
      REQ_DELETE_FIRST: begin
        is_del  = 1'b1;
        ok      = !empty;
      end
      REQ_READ_AT: begin
        is_read = 1'b1;
        ok      = pos_w < cnt_w;
        rd_idx  = SEL_W'(req_i.position);
      end
      REQ_READ_LAST: begin
        is_read = 1'b1;
        ok      = !empty;
        rd_idx  = SEL_W'(last_idx);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // broadcast to the cell row, only on a transfer that succeeds
  assign ctrl.shift_up   = req_xfer && ok && is_ins;
  assign ctrl.shift_down = req_xfer && ok && is_del;
  assign ctrl.pos        = mod_pos;
  assign ctrl.value      = req_i.value_in;

  // cell row, padded with zeros up to the read tree size
  logic signed [DATA_W-1:0] cell_val [NPAD];

  for (genvar i = 0; i < NPAD; i++) begin : g_cell
    if (i < CAPACITY) begin : g_real
      logic signed [DATA_W-1:0] prev_val, next_val;
      if (i == 0) begin : g_first
        assign prev_val = '0;
      end else begin : g_mid_p
        assign prev_val = cell_val[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign next_val = '0;
      end else begin : g_mid_n
        assign next_val = cell_val[i+1];
      end
      ilid_cell u_cell (
        .clk_i   (clk_i),
        .idx_i   (IDX_W'(i)),
        .ctrl_i  (ctrl),
        .prev_i  (prev_val),
        .next_i  (next_val),
        .value_o (cell_val[i])
      );
    end else begin : g_pad
      assign cell_val[i] = '0;
    end
  end

  // first read level: one registered pick per group, taken at the request transfer
  logic signed [DATA_W-1:0] grp_in  [NGRP][GRP];
  logic signed [DATA_W-1:0] grp_val [NGRP];

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    for (genvar k = 0; k < GRP; k++) begin : g_ent
      assign grp_in[g][k] = cell_val[g*GRP + k];
    end
    ilid_rdgrp u_rdgrp (
      .clk_i  (clk_i),
      .en_i   (req_xfer),
      .ent_i  (grp_in[g]),
      .sel_i  (rd_idx[LO_W-1:0]),
      .data_o (grp_val[g])
    );
  end

  // entry count follows the shift at the transfer
  always_comb begin
    count_d = count_q;
    if (ctrl.shift_up) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.shift_down) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // result register can load when empty or being drained
  logic rsp_free, rsp_load;
  assign rsp_free = !rsp_valid_q || rsp_o.ready;
  assign rsp_load = state_q[1] && rsp_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_xfer) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (rsp_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // request side payload, held for the run state
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      ok_q      <= ok;
      is_read_q <= is_read;
      rd_hi_q   <= rd_idx[SEL_W-1:LO_W];
    end
  end

  // second read level and result payload
  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_acc_q <= ok_q;
      rsp_cnt_q <= 8'(count_q);
      if (!is_read_q) begin
        rsp_val_q <= '0;
      end else if (ok_q) begin
        rsp_val_q <= grp_val[rd_hi_q];
      end else begin
        rsp_val_q <= VALUE_NONE;
      end
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.accepted  = rsp_acc_q;
  assign rsp_o.value_out = rsp_val_q;
  assign rsp_o.count_out = rsp_cnt_q;

endmodule

>>> sim/indexed_list_insert_delete_test.sv
`timescale 1ns / 100ps

module indexed_list_insert_delete_test;
  import ilid_pkg::*;

  // one request as queued for the driver; hold_for_drain makes the driver
  // wait until every outstanding result has come back before offering it
  typedef struct {
    ilid_req_e                kind;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    bit                       hold_for_drain;
  } list_req_t;

  // one result as the block should return it
  typedef struct {
    logic                     accepted;
    logic signed [DATA_W-1:0] value;
    logic [7:0]               count;
  } list_rsp_t;

  localparam int NUM_RANDOM    = 1625;
  localparam int QUIET_TAIL    = 200;   // no idling for the last transfers
  localparam int LONG_HOLD     = 400;   // cycles of the long result hold-off
  localparam int HOLD_AFTER    = 250;   // results taken before the long hold-off
  localparam int SETTLE_CYCLES = 20;    // wait after the scoreboard drains

  logic clk_i;
  logic rst_ni;

  ilid_req_if req_if ();
  ilid_rsp_if rsp_if ();

  indexed_list_insert_delete u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // stimulus and scoreboard storage
  list_req_t pending_reqs[$];
  list_rsp_t expected_rsps[$];
  int        num_items;
  int        sent_count;
  int        rsp_count;
  int        mismatch_count;
  int        gen_len;          // entry count as the stimulus generator tracks it

  // predicted list contents
  logic signed [DATA_W-1:0] list_mem [CAPACITY];
  int                       list_len;

  // handshake helpers
  int   send_idle_left;
  int   rsp_stall_left;
  logic hold_rsp_long;
  bit   req_fire;
  bit   offer_next;

  // clock and the single reset pulse
  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_READ_LAST;
    req_if.position = '0;
    req_if.value_in = '0;
    rsp_if.ready    = 1'b0;
    fork
      forever #5 clk_i = ~clk_i;
    join_none
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // apply one request to the predicted list and return the result it gives
  function automatic list_rsp_t apply_list_request(list_req_t req);
    list_rsp_t rsp;
    int        slot;
    int        idx;
    rsp.accepted = 1'b0;
    rsp.value    = '0;
    case (req.kind)
      REQ_INSERT_AT, REQ_APPEND, REQ_PREPEND: begin
        if (req.kind == REQ_APPEND)       slot = list_len;
        else if (req.kind == REQ_PREPEND) slot = 0;
        else                              slot = req.position;
        // refused when past the end or when the list is full
        if (slot <= list_len && list_len < CAPACITY) begin
          for (idx = list_len; idx > slot; idx--) list_mem[idx] = list_mem[idx-1];
          list_mem[slot] = req.value;
          list_len++;
          rsp.accepted = 1'b1;
        end
      end
      REQ_DELETE_AT, REQ_DELETE_LAST, REQ_DELETE_FIRST: begin
        if (req.kind == REQ_DELETE_FIRST)     slot = 0;
        else if (req.kind == REQ_DELETE_LAST) slot = (list_len > 0) ? list_len - 1 : list_len;
        else                                  slot = req.position;
        // gap closes by shifting later entries down
        if (slot < list_len) begin
          for (idx = slot; idx + 1 < list_len; idx++) list_mem[idx] = list_mem[idx+1];
          list_len--;
          rsp.accepted = 1'b1;
        end
      end
      default: begin
        // read at and read last; out of range reads give the none marker
        if (req.kind == REQ_READ_LAST) slot = (list_len > 0) ? list_len - 1 : list_len;
        else                           slot = req.position;
        if (slot < list_len) begin
          rsp.value    = list_mem[slot];
          rsp.accepted = 1'b1;
        end else begin
          rsp.value = VALUE_NONE;
        end
      end
    endcase
    rsp.count = list_len[7:0];
    return rsp;
  endfunction

  // queue one request and keep the generator's count in step
  task automatic add_req(ilid_req_e kind, int pos, logic signed [DATA_W-1:0] val,
                         bit drain = 1'b0);
    list_req_t req;
    req.kind           = kind;
    req.position       = pos[POS_W-1:0];
    req.value          = val;
    req.hold_for_drain = drain;
    pending_reqs.push_back(req);
    case (kind)
      REQ_INSERT_AT:                if (pos <= gen_len && gen_len < CAPACITY) gen_len++;
      REQ_APPEND, REQ_PREPEND:      if (gen_len < CAPACITY) gen_len++;
      REQ_DELETE_AT:                if (pos < gen_len) gen_len--;
      REQ_DELETE_LAST, REQ_DELETE_FIRST: if (gen_len > 0) gen_len--;
      default: ;
    endcase
  endtask

  // random value, now and then an extreme
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return -32'sd1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic list_req_t pending_pop();
    return pending_reqs.pop_front();
  endfunction

  task automatic check_result(list_rsp_t exp_rsp);
    if (rsp_if.accepted !== exp_rsp.accepted) begin
      $display("%0t: accepted mismatch: expected %0b actual %0b", $realtime,
               exp_rsp.accepted, rsp_if.accepted);
      mismatch_count++;
    end
    if (rsp_if.value_out !== exp_rsp.value) begin
      $display("%0t: value_out mismatch: expected %0d actual %0d", $realtime,
               exp_rsp.value, rsp_if.value_out);
      mismatch_count++;
    end
    if (rsp_if.count_out !== exp_rsp.count) begin
      $display("%0t: count_out mismatch: expected %0d actual %0d", $realtime,
               exp_rsp.count, rsp_if.count_out);
      mismatch_count++;
    end
  endtask

  // build the stimulus, then wait for the scoreboard to drain
  initial begin
    bit        grow;
    int        edge_hits;
    int        pick;
    int        pos;
    int        n;
    ilid_req_e kind;

    mismatch_count = 0;
    gen_len        = 0;
    list_len       = 0;
    hold_rsp_long  = 1'b0;

    // directed: empty list corners
    add_req(REQ_READ_AT, 0, '0);
    add_req(REQ_READ_LAST, 0, '0);
    add_req(REQ_DELETE_LAST, 0, '0);
    add_req(REQ_DELETE_FIRST, 0, '0);
    add_req(REQ_DELETE_AT, 0, '0);
    add_req(REQ_INSERT_AT, 1, 32'sd5);          // past the end
    // directed: build a small list with extreme values
    add_req(REQ_INSERT_AT, 0, 32'sh7fff_ffff);
    add_req(REQ_APPEND, 0, 32'sh8000_0000);
    add_req(REQ_PREPEND, 0, -32'sd1);
    add_req(REQ_INSERT_AT, 1, 32'sd0);
    add_req(REQ_INSERT_AT, 128, 32'sh5555_aaaa); // past the end, top position bit
    add_req(REQ_INSERT_AT, 4, 32'shaaaa_5555);  // insert at the end position
    add_req(REQ_READ_AT, 0, '0);
    add_req(REQ_READ_AT, 2, '0);
    add_req(REQ_READ_AT, 4, '0);
    add_req(REQ_READ_AT, 5, '0);                 // out of range
    add_req(REQ_READ_AT, 128, '0);               // out of range
    add_req(REQ_READ_LAST, 0, '0);
    add_req(REQ_DELETE_AT, 1, '0);
    add_req(REQ_DELETE_AT, 4, '0);               // out of range
    add_req(REQ_DELETE_LAST, 0, '0);
    add_req(REQ_DELETE_FIRST, 0, '0);
    add_req(REQ_READ_LAST, 0, '0);

    // random: sweep the list between empty and full, mostly in-range requests
    grow      = 1'b1;
    edge_hits = 0;
    for (n = 0; n < NUM_RANDOM; n++) begin
      if (grow && gen_len == CAPACITY) edge_hits++;
      if (!grow && gen_len == 0)       edge_hits++;
      if (edge_hits >= 8) begin
        grow      = ~grow;
        edge_hits = 0;
      end
      pick = $urandom_range(0, 99);
      if (pick >= 90) begin
        // noise: any request, position anywhere from the count upward
        kind = ilid_req_e'($urandom_range(0, 7));
        pos  = $urandom_range(gen_len, 128);
      end else if ((grow && pick < 55) || (!grow && pick >= 75)) begin
        case ($urandom_range(0, 2))
          0:       kind = REQ_INSERT_AT;
          1:       kind = REQ_APPEND;
          default: kind = REQ_PREPEND;
        endcase
        pos = $urandom_range(0, gen_len);
      end else if ((grow && pick < 75) || (!grow && pick < 20)) begin
        if ($urandom_range(0, 2) == 0) kind = REQ_READ_LAST;
        else                           kind = REQ_READ_AT;
        pos  = (gen_len > 0) ? $urandom_range(0, gen_len - 1) : 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       kind = REQ_DELETE_AT;
          1:       kind = REQ_DELETE_LAST;
          default: kind = REQ_DELETE_FIRST;
        endcase
        pos = (gen_len > 0) ? $urandom_range(0, gen_len - 1) : 0;
      end
      // the sender waits for a full drain at two points
      add_req(kind, pos, pick_value(), n == 700 || n == 1300);
    end
    num_items = pending_reqs.size();

    @(posedge rst_ni);
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // long result hold-off while the sender keeps offering, so the block backs up
  initial begin
    @(posedge rst_ni);
    while (rsp_count < HOLD_AFTER) @(posedge clk_i);
    hold_rsp_long <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk_i);
    hold_rsp_long <= 1'b0;
  end

  // request driver: the offered item stays at the head of the queue until its transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid   <= 1'b0;
      send_idle_left <= 0;
      sent_count     <= 0;
    end else begin
      req_fire = req_if.valid && req_if.ready;
      if (req_fire) begin
        expected_rsps.push_back(apply_list_request(pending_pop()));
        sent_count <= sent_count + 1;
      end
      if (!req_if.valid || req_fire) begin
        offer_next = pending_reqs.size() != 0 && send_idle_left == 0;
        // a drain point waits until nothing is outstanding
        if (offer_next && pending_reqs[0].hold_for_drain && expected_rsps.size() != 0)
          offer_next = 1'b0;
        if (send_idle_left > 0) send_idle_left <= send_idle_left - 1;
        // random idle bursts, with quiet stretches and a quiet tail
        if (offer_next && sent_count < num_items - QUIET_TAIL && (sent_count / 50) % 4 != 3 &&
            $urandom_range(0, 7) == 0) begin
          send_idle_left <= $urandom_range(0, 8);
          offer_next = 1'b0;
        end
        req_if.valid <= offer_next;
        if (offer_next) begin
          req_if.req_type <= pending_reqs[0].kind;
          req_if.position <= pending_reqs[0].position;
          req_if.value_in <= pending_reqs[0].value;
        end
      end
    end
  end

  // result monitor: compare every transfer with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready   <= 1'b0;
      rsp_stall_left <= 0;
      rsp_count      <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_count <= rsp_count + 1;
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result: accepted %0b value %0d count %0d", $realtime,
                   rsp_if.accepted, rsp_if.value_out, rsp_if.count_out);
          mismatch_count++;
        end else begin
          check_result(expected_rsps.pop_front());
        end
      end
      if (hold_rsp_long) begin
        rsp_if.ready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
        rsp_stall_left <= rsp_stall_left - 1;
        rsp_if.ready   <= 1'b0;
      end else if (rsp_count < num_items - QUIET_TAIL && (rsp_count / 50) % 4 != 1 &&
                   $urandom_range(0, 7) == 0) begin
        // random stall bursts on the result ready
        rsp_stall_left <= $urandom_range(0, 8);
        rsp_if.ready   <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> indexed_list_insert_delete.f
rtl/core/ilid_pkg.sv
rtl/core/ilid_if.sv
rtl/core/ilid_cell.sv
rtl/core/ilid_rdgrp.sv
rtl/core/indexed_list_insert_delete.sv
sim/indexed_list_insert_delete_test.sv
